### rtl/unsigned_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unsigned_to_decimal_ascii block
// Clocked on clk with the check held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle property.
`define U2DA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Antecedent now, consequent at the next clock edge.
`define U2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define U2DA_ASSERT(lbl, prop, msg)
`define U2DA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/u2da_pkg.sv
// ----------------------------------------------------------------------------
// u2da_pkg
// Widths, constants and shared types of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package u2da_pkg;

	// Width of the binary input value.
	localparam int VALUE_W = 32;
	// Decimal digits needed for the largest 32-bit value.
	localparam int DIGITS  = 10;
	localparam int DIGIT_W = 4;
	localparam int BCD_W   = DIGITS * DIGIT_W;
	// Width of one output character code.
	localparam int CHAR_W  = 6;
	// Index of one digit within the BCD word.
	localparam int IDX_W   = $clog2(DIGITS);
	// Counter over the shift steps of one conversion.
	localparam int STEP_W  = $clog2(VALUE_W);

	// ASCII code of the character '0'.
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	// Status of the BCD conversion unit as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} u2da_stat_t;

endpackage

### rtl/u2da_dabble.sv
// ----------------------------------------------------------------------------
// u2da_dabble
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
// ----------------------------------------------------------------------------
`include "unsigned_to_decimal_ascii_macros.svh"

module u2da_dabble import u2da_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [VALUE_W-1:0] value,
	output u2da_stat_t         stat,
	output logic [BCD_W-1:0]   bcd
);

	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               run_q;
	logic               done_q;
	logic [BCD_W-1:0]   bcd_adj;

	// Add three to every digit of five or more before the shift.
	function automatic logic [BCD_W-1:0] adjust(input logic [BCD_W-1:0] b);
		logic [BCD_W-1:0] r;
		r = b;
		for (int i = 0; i < DIGITS; i++) begin
			if (b[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				r[i*DIGIT_W +: DIGIT_W] = b[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end
		end
		return r;
	endfunction

	assign bcd_adj = adjust(bcd_q);

	// Control of the step sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(VALUE_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift register for the binary value and the growing BCD digits.
	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (run_q) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign bcd       = bcd_q;

	// A finished conversion follows the final step.
	`U2DA_ASSERT(a_done_after_run, done_q |-> (!run_q && $past(run_q)), "done without a run")
	// A new item never arrives while a conversion is under way.
	`U2DA_ASSERT(a_no_load_in_run, load |-> !run_q, "load during a conversion")
	// The step count is back at zero when the unit finishes.
	`U2DA_ASSERT(a_count_wraps, done_q |-> (cnt_q == '0), "step count off at finish")

endmodule

### rtl/unsigned_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii
// Converts a 32-bit unsigned value to decimal ASCII digits, most significant
// digit first, with leading zeros suppressed.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The block then runs
// 32 shift-and-add-3 steps in its BCD unit, locates the leading digit, and
// emits one digit per cycle, each shown for a single cycle with strobe high;
// last marks the final digit. The receiver cannot stall the output, so it
// must take every digit in the cycle it appears. An item gives 1 to 10
// digits, and busy stays high until its last digit is put out, so a new item
// is taken only after the previous one is through. The value zero gives the
// single character '0'.
// ----------------------------------------------------------------------------
`include "unsigned_to_decimal_ascii_macros.svh"

module unsigned_to_decimal_ascii import u2da_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] value,
	output logic               busy,
	output logic               strobe,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic               strobe_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic               load;
	u2da_stat_t         stat;
	logic [BCD_W-1:0]   bcd;
	logic [IDX_W-1:0]   lead_idx;
	logic [DIGIT_W-1:0] cur_digit;

	assign busy = (state_q != ST_IDLE);
	assign load = start && !busy;

	u2da_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.value  (value),
		.stat   (stat),
		.bcd    (bcd)
	);

	// Position of the most significant nonzero digit; zero gives position 0.
	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
				lead_idx = IDX_W'(i);
			end
		end
	end

	assign cur_digit = bcd[idx_q*DIGIT_W +: DIGIT_W];

	// Sequencer and registered result outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			strobe_q <= 1'b0;
			char_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (stat.done) begin
						idx_q   <= lead_idx;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					char_q   <= ASCII_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, cur_digit};
					last_q   <= (idx_q == '0);
					idx_q    <= idx_q - IDX_W'(1);
					if (idx_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe     = strobe_q;
	assign digit_char = char_q;
	assign last       = last_q;

	// Results come only out of the emit state.
	`U2DA_ASSERT(a_strobe_from_emit, strobe_q |-> $past(state_q == ST_EMIT), "stray result")
	// Every emitted character is a decimal digit.
	`U2DA_ASSERT(a_digit_range, strobe_q |-> (char_q >= ASCII_ZERO && char_q <= ASCII_ZERO + CHAR_W'(9)), "non-digit character")
	// The last marker never stands alone.
	`U2DA_ASSERT(a_last_has_strobe, last_q |-> strobe_q, "last without strobe")
	// The BCD unit runs and finishes only while a conversion is pending.
	`U2DA_ASSERT(a_unit_in_conv, (stat.busy || stat.done) |-> (state_q == ST_CONV), "unit active outside conversion")
	// An accepted item starts a conversion.
	`U2DA_ASSERT_NEXT(a_accept_conv, load, (state_q == ST_CONV && stat.busy), "accepted item not converting")

endmodule
